### src/lrlsa_pkg.sv
// ----------------------------------------------------------------------------
// lrlsa_pkg
// Shared types and constants for the least-recently-served link arbiter.
// ----------------------------------------------------------------------------
package lrlsa_pkg;

	localparam int ENTRY_COUNT  = 16;
	localparam int STAMP_WIDTH  = 31;
	localparam int IDX_W        = $clog2(ENTRY_COUNT);
	localparam int IDX_FIELD_W  = 4;
	localparam int MASK_W       = 16;
	localparam int CMD_W        = 2;
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 8;

	typedef logic [STAMP_WIDTH-1:0] stamp_t;

	localparam stamp_t STAMP_MAX = {STAMP_WIDTH{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_INSTALL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic load_in;
		logic scan_step;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic is_acquire;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

### src/least_recent_link_service_arbiter.sv
// Acquire: the result beat is registered after the entry scan, which steps
//   through the entries one at a time with a single stamp comparator.
// Release / install: no entry scan; the result is registered on apply.
// One beat in flight; the next beat is accepted once its result is registered.
// Reset clears all locks, stamps and the service tick at once.
// ----------------------------------------------------------------------------
// least_recent_link_service_arbiter
// Grants the eligible link entry with the oldest service stamp; handles
// release and install of entries.
// ----------------------------------------------------------------------------
module least_recent_link_service_arbiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// allow_connect[0], entry_index[4:1], present_mask[20:5],
	// enabled_mask[36:21], open_mask[52:37], reconnect_mask[68:53]
	input  logic [lrlsa_pkg::IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [lrlsa_pkg::CMD_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// granted[0], grant_index[4:1], fault[5]
	output logic [lrlsa_pkg::OUT_DATA_W-1:0] m_tdata
);
	import lrlsa_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	lrlsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	lrlsa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

endmodule

### src/lrlsa_ctrl.sv
// ----------------------------------------------------------------------------
// lrlsa_ctrl
// Sequencer: accept a beat, scan the entry table for an acquire, apply the update and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module lrlsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  lrlsa_pkg::dp_stat_t stat,
	output lrlsa_pkg::dp_cmd_t  cmd
);
	import lrlsa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (!stat.is_acquire || stat.scan_last) state_nxt = ST_APPLY;
			end
			ST_APPLY: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.load_in   = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.apply     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_SCAN: begin
				cmd.scan_step = stat.is_acquire;
			end
			ST_APPLY: begin
				cmd.apply = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

### src/lrlsa_dp.sv
// ----------------------------------------------------------------------------
// lrlsa_dp
// Entry table (locks, stamps, tick), sequential min-stamp scan and the
// output register.
// ----------------------------------------------------------------------------
module lrlsa_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lrlsa_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [lrlsa_pkg::CMD_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lrlsa_pkg::OUT_DATA_W-1:0] m_tdata,
	input  lrlsa_pkg::dp_cmd_t               cmd,
	output lrlsa_pkg::dp_stat_t              stat
);
	import lrlsa_pkg::*;

	// captured beat
	cmd_t                   cmd_q;
	logic                   allow_q;
	logic [IDX_FIELD_W-1:0] idx_q;
	logic [MASK_W-1:0]      pres_q;
	logic [MASK_W-1:0]      en_q;
	logic [MASK_W-1:0]      open_q;
	logic [MASK_W-1:0]      rec_q;

	// table state
	logic                   lock_q [ENTRY_COUNT];
	stamp_t                 stamp_q [ENTRY_COUNT];
	stamp_t                 tick_q;

	// scan
	logic [IDX_W-1:0]       cnt_q;
	logic                   found_q;
	logic [IDX_W-1:0]       best_q;
	stamp_t                 best_stamp_q;

	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;

	logic                   elig;
	logic                   better;
	logic                   idx_ok;
	logic [IDX_W-1:0]       idx_sel;
	logic                   res_granted;
	logic [IDX_FIELD_W-1:0] res_gidx;
	logic                   res_fault;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= cmd_t'(s_tuser);
			allow_q <= s_tdata[0];
			idx_q   <= s_tdata[4:1];
			pres_q  <= s_tdata[20:5];
			en_q    <= s_tdata[36:21];
			open_q  <= s_tdata[52:37];
			rec_q   <= s_tdata[68:53];
		end
	end

	assign elig = pres_q[cnt_q] && !lock_q[cnt_q] && (en_q[cnt_q] || open_q[cnt_q]) &&
		(allow_q || (open_q[cnt_q] && en_q[cnt_q] && !rec_q[cnt_q]));
	assign better = elig && (!found_q || (stamp_q[cnt_q] < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.load_in) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (better) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && better) begin
			best_q       <= cnt_q;
			best_stamp_q <= stamp_q[cnt_q];
		end
	end

	assign idx_ok  = (int'(idx_q) < ENTRY_COUNT);
	assign idx_sel = idx_q[IDX_W-1:0];

	always_comb begin
		res_granted = 1'b0;
		res_gidx    = '0;
		res_fault   = 1'b0;
		case (cmd_q)
			CMD_ACQUIRE: begin
				res_granted = found_q;
				res_gidx    = found_q ? IDX_FIELD_W'(best_q) : '0;
			end
			CMD_RELEASE: begin
				res_fault = !idx_ok || !lock_q[idx_sel];
			end
			default: begin
				res_granted = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				lock_q[i]  <= 1'b0;
				stamp_q[i] <= '0;
			end
			tick_q <= '0;
		end else if (cmd.apply) begin
			case (cmd_q)
				CMD_ACQUIRE: begin
					if (found_q) begin
						lock_q[best_q] <= 1'b1;
						if (tick_q == STAMP_MAX) begin
							// tick wrap: restart all stamps
							for (int i = 0; i < ENTRY_COUNT; i++) begin
								stamp_q[i] <= (IDX_W'(i) == best_q) ? stamp_t'(1) : '0;
							end
							tick_q <= stamp_t'(1);
						end else begin
							tick_q          <= tick_q + 1'b1;
							stamp_q[best_q] <= tick_q + 1'b1;
						end
					end
				end
				CMD_RELEASE: begin
					if (idx_ok) lock_q[idx_sel] <= 1'b0;
				end
				CMD_INSTALL: begin
					if (idx_ok) begin
						lock_q[idx_sel]  <= 1'b0;
						stamp_q[idx_sel] <= '0;
					end
				end
				default: begin
					tick_q <= tick_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.apply) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			m_tdata_q <= {2'b00, res_fault, res_gidx, res_granted};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.is_acquire = (cmd_q == CMD_ACQUIRE);
	assign stat.scan_last  = (int'(cnt_q) == ENTRY_COUNT - 1);
	assign stat.out_free   = !m_tvalid_q || m_tready;

endmodule
